// File: design/dtrb_pkg.sv
// Shared constants and item types for the direction to rotation basis block.
package dtrb_pkg;

    localparam int IN_WIDTH  = 16;
    localparam int FRAC_BITS = 14;
    localparam int OUT_W     = 16;

    // Widths of the squared terms and of the row-2 products
    localparam int SQ_W  = 2 * IN_WIDTH;
    localparam int LW    = 2 * SQ_W;

    // Normalizer stage counts: quotient bits, root bits, one output stage
    localparam int QB       = 2 * FRAC_BITS + 3;
    localparam int NR       = FRAC_BITS + 2;
    localparam int NORM_LAT = QB + NR + 1;
    localparam int PREP_LAT = 4;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] dir_x;
        logic signed [IN_WIDTH-1:0] dir_y;
        logic signed [IN_WIDTH-1:0] dir_z;
    } dir_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] fwd_x;
        logic signed [OUT_W-1:0] fwd_y;
        logic signed [OUT_W-1:0] fwd_z;
        logic signed [OUT_W-1:0] side_x;
        logic signed [OUT_W-1:0] side_y;
        logic signed [OUT_W-1:0] side_z;
        logic signed [OUT_W-1:0] lift_x;
        logic signed [OUT_W-1:0] lift_y;
        logic signed [OUT_W-1:0] lift_z;
        logic                    degenerate;
    } basis_t;

    // Signs of the output components that can be negative, fixed at the first stage
    typedef struct packed {
        logic fx;
        logic fy;
        logic fz;
        logic sx;
        logic sy;
        logic lx;
        logic ly;
    } sign_t;

    // Numerators and denominators handed to the normalizers
    typedef struct packed {
        logic [SQ_W-1:0] ax2;
        logic [SQ_W-1:0] ay2;
        logic [SQ_W-1:0] az2;
        logic [SQ_W-1:0] rr;
        logic [SQ_W-1:0] ll;
        logic [LW-1:0]   nlx;
        logic [LW-1:0]   nly;
        logic [LW-1:0]   nlz;
        logic [LW-1:0]   dl;
        logic            degen;
        sign_t           sgn;
    } prep_t;

endpackage

// File: design/dtrb_prep.sv
// Front pipeline: magnitudes, squares, row sums and row-2 products.
module dtrb_prep
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  dtrb_pkg::dir_t      dir,
    output logic                out_valid,
    output dtrb_pkg::prep_t     prep
);

    localparam int IW   = dtrb_pkg::IN_WIDTH;
    localparam int SQW  = dtrb_pkg::SQ_W;
    localparam int LW   = dtrb_pkg::LW;

    // Stage 1: magnitudes and signs
    logic              v1_reg;
    logic [IW-1:0]     ax_reg, ay_reg, az_reg;
    dtrb_pkg::sign_t   sg1_reg;
    logic [IW-1:0]     ax_next, ay_next, az_next;
    dtrb_pkg::sign_t   sg_next;

    // Stage 2: squares and cross products
    logic              v2_reg;
    logic [SQW-1:0]    ax2_reg, ay2_reg, az2_reg, zx_reg, zy_reg;
    dtrb_pkg::sign_t   sg2_reg;

    // Stage 3: row sums
    logic              v3_reg;
    logic [SQW-1:0]    ax2b_reg, ay2b_reg, az2b_reg, zxb_reg, zyb_reg, rr_reg, ll_reg;
    dtrb_pkg::sign_t   sg3_reg;

    // Stage 4: wide products
    logic              v4_reg;
    dtrb_pkg::prep_t   p4_reg;
    dtrb_pkg::prep_t   p4_next;

    logic xn, yn, zn, xz, yz, zz;

    always_comb
    begin
        xn = dir.dir_x[IW-1];
        yn = dir.dir_y[IW-1];
        zn = dir.dir_z[IW-1];
        xz = (dir.dir_x == '0);
        yz = (dir.dir_y == '0);
        zz = (dir.dir_z == '0);
        ax_next = xn ? IW'(-dir.dir_x) : IW'(dir.dir_x);
        ay_next = yn ? IW'(-dir.dir_y) : IW'(dir.dir_y);
        az_next = zn ? IW'(-dir.dir_z) : IW'(dir.dir_z);
        sg_next.fx = xn;
        sg_next.fy = yn;
        sg_next.fz = zn;
        sg_next.sx = !yn && !yz;
        sg_next.sy = xn;
        sg_next.lx = (zn == xn) && !zz && !xz;
        sg_next.ly = (zn == yn) && !zz && !yz;
    end

    always_comb
    begin
        p4_next.ax2   = ax2b_reg;
        p4_next.ay2   = ay2b_reg;
        p4_next.az2   = az2b_reg;
        p4_next.rr    = rr_reg;
        p4_next.ll    = ll_reg;
        p4_next.nlx   = LW'(zxb_reg) * LW'(zxb_reg);
        p4_next.nly   = LW'(zyb_reg) * LW'(zyb_reg);
        p4_next.nlz   = LW'(rr_reg) * LW'(rr_reg);
        p4_next.dl    = LW'(rr_reg) * LW'(ll_reg);
        p4_next.degen = (rr_reg == '0);
        p4_next.sgn   = sg3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        az_reg   <= az_next;
        sg1_reg  <= sg_next;

        ax2_reg  <= SQW'(ax_reg) * SQW'(ax_reg);
        ay2_reg  <= SQW'(ay_reg) * SQW'(ay_reg);
        az2_reg  <= SQW'(az_reg) * SQW'(az_reg);
        zx_reg   <= SQW'(az_reg) * SQW'(ax_reg);
        zy_reg   <= SQW'(az_reg) * SQW'(ay_reg);
        sg2_reg  <= sg1_reg;

        ax2b_reg <= ax2_reg;
        ay2b_reg <= ay2_reg;
        az2b_reg <= az2_reg;
        zxb_reg  <= zx_reg;
        zyb_reg  <= zy_reg;
        rr_reg   <= ax2_reg + ay2_reg;
        ll_reg   <= ax2_reg + ay2_reg + az2_reg;
        sg3_reg  <= sg2_reg;

        p4_reg   <= p4_next;
    end

    assign out_valid = v4_reg;
    assign prep      = p4_reg;

endmodule

// File: design/dtrb_norm.sv
// Normalizer: round(sqrt(num / den) * 2^FRAC_BITS) by long division then square root.
module dtrb_norm #(
    parameter int DW = 32
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [DW-1:0]                   num,
    input  logic [DW-1:0]                   den,
    input  logic                            neg,
    output logic                            out_valid,
    output logic signed [dtrb_pkg::OUT_W-1:0] res
);

    localparam int QB  = dtrb_pkg::QB;
    localparam int NR  = dtrb_pkg::NR;
    localparam int OW  = dtrb_pkg::OUT_W;
    localparam int RW  = DW + 1;
    localparam int SW  = 2 * NR;
    localparam int RMW = NR + 2;

    // Division pipeline: one quotient bit per stage
    logic [RW-1:0] drem_reg [QB];
    logic [QB-1:0] dquo_reg [QB];
    logic [DW-1:0] dden_reg [QB];
    logic          dneg_reg [QB];
    logic          dzero_reg [QB];
    logic          dval_reg [QB];

    // Square root pipeline: one root bit per stage
    logic [SW-1:0]  srad_reg [NR];
    logic [RMW-1:0] srem_reg [NR];
    logic [NR-1:0]  sroot_reg [NR];
    logic           sneg_reg [NR];
    logic           szero_reg [NR];
    logic           sval_reg [NR];

    logic                 oval_reg;
    logic signed [OW-1:0] res_reg;

    genvar k;
    generate
        for (k = 0; k < QB; k++)
        begin : g_div
            logic [RW-1:0] r2;
            logic [DW-1:0] dsrc;
            logic          ge;
            logic [RW-1:0] rem_next;
            logic [QB-1:0] quo_next;
            logic          neg_src, zero_src, val_src;

            if (k == 0)
            begin : g_first
                always_comb
                begin
                    r2       = {1'b0, num};
                    dsrc     = den;
                    quo_next = '0;
                    neg_src  = neg;
                    zero_src = (num == '0) || (den == '0);
                    val_src  = in_valid;
                end
            end
            else
            begin : g_next
                always_comb
                begin
                    r2       = {drem_reg[k-1][DW-1:0], 1'b0};
                    dsrc     = dden_reg[k-1];
                    quo_next = {dquo_reg[k-1][QB-2:0], 1'b0};
                    neg_src  = dneg_reg[k-1];
                    zero_src = dzero_reg[k-1];
                    val_src  = dval_reg[k-1];
                end
            end

            always_comb
            begin
                ge       = (r2 >= {1'b0, dsrc});
                rem_next = ge ? (r2 - {1'b0, dsrc}) : r2;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dval_reg[k] <= 1'b0;
                end
                else
                begin
                    dval_reg[k] <= val_src;
                end
            end

            always_ff @(posedge clk)
            begin
                drem_reg[k]  <= rem_next;
                dquo_reg[k]  <= {quo_next[QB-1:1], ge};
                dden_reg[k]  <= dsrc;
                dneg_reg[k]  <= neg_src;
                dzero_reg[k] <= zero_src;
            end
        end

        for (k = 0; k < NR; k++)
        begin : g_sqrt
            logic [SW-1:0]  rad;
            logic [RMW-1:0] rem;
            logic [NR-1:0]  root;
            logic [RMW-1:0] rem2;
            logic [RMW-1:0] trial;
            logic           ge;
            logic           neg_src, zero_src, val_src;

            if (k == 0)
            begin : g_first
                always_comb
                begin
                    rad      = SW'(dquo_reg[QB-1]);
                    rem      = '0;
                    root     = '0;
                    neg_src  = dneg_reg[QB-1];
                    zero_src = dzero_reg[QB-1];
                    val_src  = dval_reg[QB-1];
                end
            end
            else
            begin : g_next
                always_comb
                begin
                    rad      = srad_reg[k-1];
                    rem      = srem_reg[k-1];
                    root     = sroot_reg[k-1];
                    neg_src  = sneg_reg[k-1];
                    zero_src = szero_reg[k-1];
                    val_src  = sval_reg[k-1];
                end
            end

            always_comb
            begin
                rem2  = {rem[RMW-3:0], rad[SW-1:SW-2]};
                trial = {root, 2'b01};
                ge    = (rem2 >= trial);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sval_reg[k] <= 1'b0;
                end
                else
                begin
                    sval_reg[k] <= val_src;
                end
            end

            always_ff @(posedge clk)
            begin
                srad_reg[k]  <= {rad[SW-3:0], 2'b00};
                srem_reg[k]  <= ge ? (rem2 - trial) : rem2;
                sroot_reg[k] <= {root[NR-2:0], ge};
                sneg_reg[k]  <= neg_src;
                szero_reg[k] <= zero_src;
            end
        end
    endgenerate

    // Round half away: largest L with 2L-1 <= isqrt(T)
    logic [NR:0]          lsum;
    logic [OW-1:0]        mag;
    logic signed [OW-1:0] res_next;

    always_comb
    begin
        lsum = {1'b0, sroot_reg[NR-1]} + (NR+1)'(1);
        mag  = OW'(lsum[NR:1]);
        if (szero_reg[NR-1])
        begin
            res_next = '0;
        end
        else if (sneg_reg[NR-1])
        begin
            res_next = -$signed(mag);
        end
        else
        begin
            res_next = $signed(mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oval_reg <= 1'b0;
        end
        else
        begin
            oval_reg <= sval_reg[NR-1];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = oval_reg;
    assign res       = res_reg;

endmodule

// File: design/direction_to_rotation_basis.sv
// Direction to rotation basis: pipelined look-at basis against world up, Q1.14 out.
// Each item passes the prep stages, the division and root stages and the output register.
// Throughput: one item per cycle; the per-bit division and root stages set the depth.
// busy is always low; done pulses for one cycle with each basis.
// Reset clears the valid bits only; data registers are not reset.
module direction_to_rotation_basis
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  dtrb_pkg::dir_t    dir,
    output logic              done,
    output dtrb_pkg::basis_t  basis
);

    localparam int SQW = dtrb_pkg::SQ_W;
    localparam int LW  = dtrb_pkg::LW;
    localparam int NL  = dtrb_pkg::NORM_LAT;
    localparam int OW  = dtrb_pkg::OUT_W;

    logic            pv;
    dtrb_pkg::prep_t pp;

    logic [NL-1:0]   degen_reg;

    logic                 v_fx;
    logic signed [OW-1:0] r_fx, r_fy, r_fz, r_sx, r_sy, r_lx, r_ly, r_lz;

    assign busy = 1'b0;

    dtrb_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .dir       (dir),
        .out_valid (pv),
        .prep      (pp)
    );

    dtrb_norm #(.DW(SQW)) u_fx
    (
        .clk(clk), .rst_n(rst_n), .in_valid(pv),
        .num(pp.ax2), .den(pp.ll), .neg(pp.sgn.fx),
        .out_valid(v_fx), .res(r_fx)
    );

    dtrb_norm #(.DW(SQW)) u_fy
    (
        .clk(clk), .rst_n(rst_n), .in_valid(pv),
        .num(pp.ay2), .den(pp.ll), .neg(pp.sgn.fy),
        .out_valid(), .res(r_fy)
    );

    dtrb_norm #(.DW(SQW)) u_fz
    (
        .clk(clk), .rst_n(rst_n), .in_valid(pv),
        .num(pp.az2), .den(pp.ll), .neg(pp.sgn.fz),
        .out_valid(), .res(r_fz)
    );

    dtrb_norm #(.DW(SQW)) u_sx
    (
        .clk(clk), .rst_n(rst_n), .in_valid(pv),
        .num(pp.ay2), .den(pp.rr), .neg(pp.sgn.sx),
        .out_valid(), .res(r_sx)
    );

    dtrb_norm #(.DW(SQW)) u_sy
    (
        .clk(clk), .rst_n(rst_n), .in_valid(pv),
        .num(pp.ax2), .den(pp.rr), .neg(pp.sgn.sy),
        .out_valid(), .res(r_sy)
    );

    dtrb_norm #(.DW(LW)) u_lx
    (
        .clk(clk), .rst_n(rst_n), .in_valid(pv),
        .num(pp.nlx), .den(pp.dl), .neg(pp.sgn.lx),
        .out_valid(), .res(r_lx)
    );

    dtrb_norm #(.DW(LW)) u_ly
    (
        .clk(clk), .rst_n(rst_n), .in_valid(pv),
        .num(pp.nly), .den(pp.dl), .neg(pp.sgn.ly),
        .out_valid(), .res(r_ly)
    );

    dtrb_norm #(.DW(LW)) u_lz
    (
        .clk(clk), .rst_n(rst_n), .in_valid(pv),
        .num(pp.nlz), .den(pp.dl), .neg(1'b0),
        .out_valid(), .res(r_lz)
    );

    // Carry the degenerate flag alongside the normalizers
    always_ff @(posedge clk)
    begin
        degen_reg <= {degen_reg[NL-2:0], pp.degen};
    end

    always_comb
    begin
        basis.fwd_x      = r_fx;
        basis.fwd_y      = r_fy;
        basis.fwd_z      = r_fz;
        basis.side_x     = r_sx;
        basis.side_y     = r_sy;
        basis.side_z     = '0;
        basis.lift_x     = r_lx;
        basis.lift_y     = r_ly;
        basis.lift_z     = r_lz;
        basis.degenerate = degen_reg[NL-1];
    end

    assign done = v_fx;

endmodule
